// ===== sv/lir_pkg.sv =====
// lir_pkg: shared constants, register map and control structs of the
// linear interpolation resampler. No dependencies.
package lir_pkg;

  localparam int LIR_MAX_CHANNELS  = 8;
  localparam int LIR_FRACTION_BITS = 32;
  localparam int LIR_MAX_UPSAMPLE  = 16;

  localparam int SAMPLE_W = 16;
  localparam int NUM_FIELDS = 8;
  localparam int DATA_W = SAMPLE_W * NUM_FIELDS;
  localparam int STEP_W = 37;
  localparam int CHAN_W = 4;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);

  // register index within the map, byte address is 8 * index
  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_CHANS = 1'b1;

  // request handed from the phase sequencer to the lane pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

  // frame store updates driven by the phase sequencer
  typedef struct packed {
    logic cur_from_in;
    logic prev_from_in;
    logic prev_from_cur;
  } frame_ctl_t;

endpackage

// ===== sv/lir_lane.sv =====
// lir_lane: one channel lane, registered (cur - prev) * frac product and
// truncating sum. Depends on lir_pkg.
module lir_lane import lir_pkg::*; #(
  parameter int FRACTION_BITS = LIR_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       en,
  input  logic signed [SAMPLE_W-1:0] prev,
  input  logic signed [SAMPLE_W-1:0] cur,
  input  logic [FRACTION_BITS-1:0]   frac,
  output logic signed [SAMPLE_W-1:0] res
);

  localparam int NUM_W = SAMPLE_W + FRACTION_BITS + 2;

  logic signed [SAMPLE_W:0]       diff;
  logic signed [NUM_W-1:0]        prod_nxt;
  logic signed [NUM_W-1:0]        prod_r;
  logic signed [SAMPLE_W-1:0]     base_r;
  logic signed [NUM_W-1:0]        num;
  logic signed [NUM_W-1:0]        bias;
  logic signed [NUM_W-1:0]        shifted;

  assign diff = $signed({cur[SAMPLE_W-1], cur}) - $signed({prev[SAMPLE_W-1], prev});
  assign prod_nxt = NUM_W'(diff) * NUM_W'($signed({1'b0, frac}));

  always_ff @(posedge clk) begin
    if (load) begin
      base_r <= en ? prev : '0;
      prod_r <= en ? prod_nxt : '0;
    end
  end

  // truncate toward zero
  assign num = $signed({{2{base_r[SAMPLE_W-1]}}, base_r, {FRACTION_BITS{1'b0}}}) + prod_r;
  assign bias = num[NUM_W-1] ? $signed({{(NUM_W-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}})
                             : '0;
  assign shifted = (num + bias) >>> FRACTION_BITS;
  assign res = shifted[SAMPLE_W-1:0];

endmodule

// ===== sv/lir_seq.sv =====
// lir_seq: phase accumulator and run sequencer, one output frame request per
// cycle while the phase is below one and issue_ready is high. Depends on lir_pkg.
module lir_seq import lir_pkg::*; #(
  parameter int FRACTION_BITS = LIR_FRACTION_BITS,
  parameter int MAX_UPSAMPLE  = LIR_MAX_UPSAMPLE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  output logic                       in_ready,
  input  logic [FRACTION_BITS+4:0]   step,
  input  logic                       issue_ready,
  output issue_t                     issue,
  output logic [FRACTION_BITS-1:0]   frac,
  output frame_ctl_t                 frame_ctl
);

  localparam int PHASE_W = FRACTION_BITS + 5;
  localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);
  localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << FRACTION_BITS;

  typedef enum logic {IDLE, RUN} state_t;

  state_t             state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               primed_r, primed_nxt;
  logic [PHASE_W-1:0] phase_add;
  logic               whole;
  logic               last;
  logic               adv;

  assign phase_add = phase_r + step;
  assign whole = (phase_r[PHASE_W-1:FRACTION_BITS] != '0);
  assign last = (phase_add[PHASE_W-1:FRACTION_BITS] != '0) ||
                (count_r == CNT_W'(MAX_UPSAMPLE - 1));
  assign in_ready = (state_r == IDLE);
  assign frac = phase_r[FRACTION_BITS-1:0];
  assign issue.valid = (state_r == RUN);
  assign issue.last = last;
  assign adv = issue.valid && issue_ready;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    primed_nxt = primed_r;
    frame_ctl = '0;
    case (state_r)
      IDLE: begin
        if (in_fire) begin
          if (!primed_r) begin
            primed_nxt = 1'b1;
            frame_ctl.prev_from_in = 1'b1;
          end else if (whole) begin
            phase_nxt = phase_r - ONE;
            frame_ctl.prev_from_in = 1'b1;
          end else begin
            count_nxt = '0;
            frame_ctl.cur_from_in = 1'b1;
            state_nxt = RUN;
          end
        end
      end
      RUN: begin
        if (adv) begin
          if (last) begin
            phase_nxt = (phase_add >= ONE) ? phase_add - ONE : '0;
            frame_ctl.prev_from_cur = 1'b1;
            state_nxt = IDLE;
          end else begin
            phase_nxt = phase_add;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      phase_r <= '0;
      count_r <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

// ===== sv/lir_merge.sv =====
// lir_merge: product stage valid tracking and output register that packs the
// lane results into one output frame. Depends on lir_pkg.
module lir_merge import lir_pkg::*; #(
  parameter int MAX_CHANNELS = LIR_MAX_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  issue_t                                issue,
  output logic                                  issue_ready,
  input  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lane_res,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [DATA_W-1:0]                     out_tdata,
  output logic                                  out_tlast
);

  logic              s1_valid_r;
  logic              s1_last_r;
  logic              out_valid_r;
  logic              out_last_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] packed_nxt;
  logic              out_adv;

  assign out_adv = !out_valid_r || out_tready;
  assign issue_ready = !s1_valid_r || out_adv;

  always_comb begin
    packed_nxt = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      packed_nxt[c*SAMPLE_W +: SAMPLE_W] = lane_res[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue.valid && issue_ready) begin
        s1_valid_r <= 1'b1;
      end else if (out_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid && issue_ready) begin
      s1_last_r <= issue.last;
    end
    if (out_adv) begin
      out_data_r <= packed_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule

// ===== sv/linear_interp_resampler_top.sv =====
// linear_interp_resampler_top: multichannel linear interpolation resampler,
// config registers, frame store, sequencer, lanes and output merge.
// Depends on lir_pkg, lir_seq, lir_lane, lir_merge.
//
//   port group | dir | payload
//   in_*       | in  | tdata: sample_0..sample_7, 16 bits each, lowest first
//   out_*      | out | tdata: out_0..out_7, 16 bits each; tlast: last_in_run
//   cfg_*      | in  | step_increment at 0x0, active_channels at 0x8
//
// an input frame that causes n outputs holds the input side while the phase
// sequencer issues one output frame request per cycle, unless the output stalls.
// a frame with no output (first frame or phase at or above one) is taken without leaving IDLE.
// results pass through the lane product registers and the merge output register; a
// stalled output holds the pipeline while in_tready stays low until the run is issued.
// synchronous active-low reset clears control state, the config registers and prev_r.
module linear_interp_resampler_top import lir_pkg::*; #(
  parameter int MAX_CHANNELS  = LIR_MAX_CHANNELS,
  parameter int FRACTION_BITS = LIR_FRACTION_BITS,
  parameter int MAX_UPSAMPLE  = LIR_MAX_UPSAMPLE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,    // sample_0 .. sample_7
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,   // out_0 .. out_7
  output logic                  out_tlast,   // last_in_run
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int PHASE_W = FRACTION_BITS + 5;
  localparam logic [STEP_W-1:0] ONE_S = STEP_W'(1) << FRACTION_BITS;
  localparam logic [STEP_W-1:0] MIN_STEP = (ONE_S + STEP_W'(MAX_UPSAMPLE - 1)) /
                                           STEP_W'(MAX_UPSAMPLE);
  localparam logic [STEP_W-1:0] MAX_STEP = ONE_S << 4;

  logic [STEP_W-1:0]   step_r;
  logic [CHAN_W-1:0]   chans_r;
  logic                cfg_wr;
  logic                reg_sel;
  logic [STEP_W-1:0]   step_clamp;
  logic [CHAN_W-1:0]   chans_eff;
  logic                in_fire;
  logic                issue_ready;
  issue_t              issue;
  frame_ctl_t          frame_ctl;
  logic [FRACTION_BITS-1:0] frac;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] prev_r;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] cur_r;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lane_res;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel = cfg_paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ONE_S;
      chans_r <= CHAN_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_STEP:  step_r <= cfg_pwdata[STEP_W-1:0];
        REG_CHANS: chans_r <= cfg_pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP:  cfg_prdata = CFG_DATA_W'(step_r);
      REG_CHANS: cfg_prdata = CFG_DATA_W'(chans_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign step_clamp = (step_r < MIN_STEP) ? MIN_STEP :
                      (step_r > MAX_STEP) ? MAX_STEP : step_r;

  always_comb begin
    if (chans_r == '0) begin
      chans_eff = CHAN_W'(1);
    end else if (chans_r > CHAN_W'(MAX_CHANNELS)) begin
      chans_eff = CHAN_W'(MAX_CHANNELS);
    end else begin
      chans_eff = chans_r;
    end
  end

  // frame store
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (frame_ctl.prev_from_in) begin
      prev_r <= in_tdata[MAX_CHANNELS*SAMPLE_W-1:0];
    end else if (frame_ctl.prev_from_cur) begin
      prev_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ctl.cur_from_in) begin
      cur_r <= in_tdata[MAX_CHANNELS*SAMPLE_W-1:0];
    end
  end

  lir_seq #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_UPSAMPLE  (MAX_UPSAMPLE)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_ready    (in_tready),
    .step        (step_clamp[PHASE_W-1:0]),
    .issue_ready (issue_ready),
    .issue       (issue),
    .frac        (frac),
    .frame_ctl   (frame_ctl)
  );

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    lir_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk  (clk),
      .load (issue.valid && issue_ready),
      .en   (CHAN_W'(c) < chans_eff),
      .prev (prev_r[c]),
      .cur  (cur_r[c]),
      .frac (frac),
      .res  (lane_res[c])
    );
  end

  lir_merge #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .issue_ready (issue_ready),
    .lane_res    (lane_res),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
